FILE: hw/rtl/ascii_integer_parser_macros.svh
// Assertion macros for the integer parser.
// Both sample on clk and are disabled while rst_n is low.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication.
`define AIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AIP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/aip_pkg.sv
package aip_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int RESULT_BITS        = 32;
    localparam int CHAR_BITS          = 8;
    localparam int CNT_BITS           = 6;

    localparam logic [CNT_BITS-1:0] COUNT_MAX = 6'd63;

    // item kinds
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // parser phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_ZERO  = 3'd2;
    localparam logic [2:0] PH_DEC   = 3'd3;
    localparam logic [2:0] PH_HEX   = 3'd4;
    localparam logic [2:0] PH_BIN   = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_BITS-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;

    function automatic logic is_dec(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // {invalid, nibble}: bit 4 set when c is no hex digit
    function automatic logic [4:0] hex_val(input logic [CHAR_BITS-1:0] c);
        logic [4:0] r;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r = {1'b0, c[3:0]};
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            r = 5'(c - 8'h57);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            r = 5'(c - 8'h37);
        end
        else
        begin
            r = 5'd16;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/aip_in_if.sv
interface aip_in_if;
    import aip_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [CHAR_BITS-1:0] ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);
endinterface

FILE: hw/rtl/aip_out_if.sv
interface aip_out_if;
    import aip_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [RESULT_BITS-1:0] value;
    logic                          ok;

    modport source (output valid, output value, output ok, input ready);
    modport sink   (input valid, input value, input ok, output ready);
endinterface

FILE: hw/rtl/ascii_integer_parser.sv
// Channel | Dir | Payload                  | Notes
// req     | in  | cmd[0], ch[7:0]          | cmd 0 = one character, 1 = end of string
// rsp     | out | value[31:0] signed, ok   | one item per end-of-string item
//
// Two register stages: an input register, then parser state plus result register.
// One character per cycle sustained; an end item goes through the input register, then loads the result register.
// Rate is set by the per-character state update (shift-add on the accumulator).
// rst_n (async, active low) clears both stage valids and the parser state.
// Character items never wait on rsp; an end item waits in the input register
// only while the result register is full and rsp.ready is low.
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser #(
    parameter int VALUE_BITS = aip_pkg::DEFAULT_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    aip_in_if.sink    req,
    aip_out_if.source rsp
);
    import aip_pkg::*;

    localparam int HEX_MAX = VALUE_BITS / 4;
    localparam int BIN_MAX = VALUE_BITS;

    // input register
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_cmd_reg;
    logic [CHAR_BITS-1:0] s1_ch_reg;

    // parser state
    logic [2:0]            phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic signed [RESULT_BITS-1:0] value_reg, value_next;
    logic                          ok_reg, ok_next;

    logic                  s1_adv;
    logic                  take_in;
    logic                  load_out;
    logic [CNT_BITS-1:0]   count_inc;
    logic [VALUE_BITS-1:0] acc_dec;
    logic [4:0]            hex_k;
    logic                  ch_dec;
    logic                  good;
    logic signed [VALUE_BITS-1:0] signed_val;

    // stage 1 moves on unless it is an end item blocked by a full result register
    assign s1_adv   = s1_valid_reg &&
                      (s1_cmd_reg == CMD_CHAR || !out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign take_in  = req.valid && req.ready;
    assign load_out = s1_adv && (s1_cmd_reg == CMD_END);

    assign s1_valid_next = take_in || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_cmd_reg <= req.cmd;
            s1_ch_reg  <= req.ch;
        end
    end

    // digit datapath
    assign ch_dec    = is_dec(s1_ch_reg);
    assign hex_k     = hex_val(s1_ch_reg);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    // acc * 10 + digit, wraps at VALUE_BITS
    assign acc_dec   = (acc_reg << 3) + (acc_reg << 1) + VALUE_BITS'(s1_ch_reg[3:0]);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        if (s1_adv && s1_cmd_reg == CMD_END)
        begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            count_next = '0;
            acc_next   = '0;
        end
        else if (s1_adv)
        begin
            case (phase_reg)
                PH_START, PH_SIGN:
                begin
                    if (phase_reg == PH_START && s1_ch_reg == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (s1_ch_reg == CH_ZERO)
                    begin
                        acc_next   = '0;
                        count_next = CNT_BITS'(1);
                        phase_next = PH_ZERO;
                    end
                    else if (ch_dec)
                    begin
                        acc_next   = VALUE_BITS'(s1_ch_reg[3:0]);
                        count_next = CNT_BITS'(1);
                        phase_next = PH_DEC;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_ZERO:
                begin
                    if (s1_ch_reg == CH_LX || s1_ch_reg == CH_UX)
                    begin
                        acc_next   = '0;
                        count_next = '0;
                        phase_next = PH_HEX;
                    end
                    else if (s1_ch_reg == CH_LB || s1_ch_reg == CH_UB)
                    begin
                        acc_next   = '0;
                        count_next = '0;
                        phase_next = PH_BIN;
                    end
                    else if (ch_dec)
                    begin
                        acc_next   = acc_dec;
                        count_next = count_inc;
                        phase_next = PH_DEC;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_DEC:
                begin
                    if (ch_dec)
                    begin
                        acc_next   = acc_dec;
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_HEX:
                begin
                    if (!hex_k[4])
                    begin
                        acc_next   = {acc_reg[VALUE_BITS-5:0], hex_k[3:0]};
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_BIN:
                begin
                    if (s1_ch_reg == CH_ZERO || s1_ch_reg == CH_ONE)
                    begin
                        acc_next   = {acc_reg[VALUE_BITS-2:0], s1_ch_reg[0]};
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                    // error phase and the unused code stay in error
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    // end-of-string check and sign
    always_comb
    begin
        case (phase_reg)
            PH_ZERO, PH_DEC:
            begin
                good = 1'b1;
            end
            PH_HEX:
            begin
                good = (count_reg != '0) &&
                       ({1'b0, count_reg} <= (CNT_BITS + 1)'(HEX_MAX));
            end
            PH_BIN:
            begin
                good = (count_reg != '0) &&
                       (32'(count_reg) <= 32'(BIN_MAX));
            end
            default:
            begin
                good = 1'b0;
            end
        endcase
    end

    assign signed_val = neg_reg ? signed'(-acc_reg) : signed'(acc_reg);
    assign value_next = good ? RESULT_BITS'(signed_val) : '0;
    assign ok_next    = good;

    assign out_valid_next = load_out || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg <= value_next;
            ok_reg    <= ok_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = value_reg;
    assign rsp.ok    = ok_reg;

    // checks
    `AIP_ASSERT_IMP(a_bad_is_zero, out_valid_reg && !ok_reg, value_reg == '0, "failed parse with nonzero value")
    `AIP_ASSERT_NXT(a_end_clears, load_out, phase_reg == PH_START && count_reg == '0 && !neg_reg, "state not cleared after end item")
    `AIP_ASSERT_IMP(a_start_clean, phase_reg == PH_START, acc_reg == '0 && !neg_reg, "start phase with stale state")
    `AIP_ASSERT_IMP(a_stall_cause, !req.ready, s1_valid_reg && s1_cmd_reg == CMD_END && out_valid_reg, "input stalled without a blocked end item")

endmodule

FILE: tb/aip_checker.sv
// Watches both channels of the integer parser, predicts each result and
// compares it field by field with what the block returns.
module aip_checker (
    input  logic clk,
    input  logic rst_n,
    aip_in_if    req,
    aip_out_if   rsp,
    output int   errors,
    output int   pending
);
    import aip_pkg::*;

    localparam int VBITS          = DEFAULT_VALUE_BITS;
    localparam int HEX_DIGITS_MAX = VBITS / 4;
    localparam int BIN_DIGITS_MAX = VBITS;
    localparam int MAX_PRINTED    = 30;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] value;
        logic                          ok;
    } parse_result_t;

    // predicted parser state
    logic [2:0]          phase;
    logic                minus_seen;
    logic [CNT_BITS-1:0] n_digits;
    logic [VBITS-1:0]    magnitude;

    parse_result_t results_due[$];

    function automatic bit decimal_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // -1 when c is no hex digit
    function automatic int hex_digit_value(input logic [CHAR_BITS-1:0] c);
        if (decimal_digit(c))
        begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LA && c <= CH_LF)
        begin
            return int'(c - CH_LA) + 10;
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return int'(c - CH_UA) + 10;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
        begin
            $display("aip_checker: %s", what);
        end
    endtask

    task automatic clear_state();
        phase      = PH_START;
        minus_seen = 1'b0;
        n_digits   = '0;
        magnitude  = '0;
    endtask

    task automatic count_digit();
        if (n_digits != COUNT_MAX)
        begin
            n_digits++;
        end
    endtask

    // decimal shift-add, wraps at the accumulator width
    task automatic add_decimal(input logic [CHAR_BITS-1:0] c);
        logic [VBITS+3:0] wide;
        wide      = magnitude * 10 + (c - CH_ZERO);
        magnitude = wide[VBITS-1:0];
        count_digit();
    endtask

    task automatic take_char(input logic [CHAR_BITS-1:0] c);
        int nib;
        nib = hex_digit_value(c);
        case (phase)
            PH_START, PH_SIGN:
            begin
                if (phase == PH_START && c == CH_MINUS)
                begin
                    minus_seen = 1'b1;
                    phase      = PH_SIGN;
                end
                else if (c == CH_ZERO)
                begin
                    magnitude = '0;
                    n_digits  = CNT_BITS'(1);
                    phase     = PH_ZERO;
                end
                else if (decimal_digit(c))
                begin
                    magnitude = '0;
                    add_decimal(c);
                    phase = PH_DEC;
                end
                else
                begin
                    phase = PH_ERR;
                end
            end
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    magnitude = '0;
                    n_digits  = '0;
                    phase     = PH_HEX;
                end
                else if (c == CH_LB || c == CH_UB)
                begin
                    magnitude = '0;
                    n_digits  = '0;
                    phase     = PH_BIN;
                end
                else if (decimal_digit(c))
                begin
                    add_decimal(c);
                    phase = PH_DEC;
                end
                else
                begin
                    phase = PH_ERR;
                end
            end
            PH_DEC:
            begin
                if (decimal_digit(c))
                begin
                    add_decimal(c);
                end
                else
                begin
                    phase = PH_ERR;
                end
            end
            PH_HEX:
            begin
                if (nib >= 0)
                begin
                    magnitude = {magnitude[VBITS-5:0], 4'(nib)};
                    count_digit();
                end
                else
                begin
                    phase = PH_ERR;
                end
            end
            PH_BIN:
            begin
                if (c == CH_ZERO || c == CH_ONE)
                begin
                    magnitude = {magnitude[VBITS-2:0], c[0]};
                    count_digit();
                end
                else
                begin
                    phase = PH_ERR;
                end
            end
            default:
            begin
                phase = PH_ERR;
            end
        endcase
    endtask

    task automatic close_string(output parse_result_t r);
        logic             good;
        logic [VBITS-1:0] v;
        case (phase)
            PH_ZERO, PH_DEC:
            begin
                good = 1'b1;
            end
            PH_HEX:
            begin
                good = (n_digits >= 1) && (n_digits <= HEX_DIGITS_MAX);
            end
            PH_BIN:
            begin
                good = (n_digits >= 1) && (n_digits <= BIN_DIGITS_MAX);
            end
            default:
            begin
                good = 1'b0;
            end
        endcase
        v = '0;
        if (good)
        begin
            v = minus_seen ? -magnitude : magnitude;
        end
        r.value = signed'(v);
        r.ok    = good;
        clear_state();
    endtask

    task automatic check_result();
        parse_result_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result value %0d ok %0b",
                                      rsp.value, rsp.ok));
        end
        else
        begin
            want = results_due.pop_front();
            if (rsp.value !== want.value)
            begin
                report_mismatch($sformatf("value %0d, expected %0d",
                                          rsp.value, want.value));
            end
            if (rsp.ok !== want.ok)
            begin
                report_mismatch($sformatf("ok %0b, expected %0b", rsp.ok, want.ok));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t r;
        if (!rst_n)
        begin
            clear_state();
            results_due.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                check_result();
            end
            if (req.valid && req.ready)
            begin
                if (req.cmd == CMD_END)
                begin
                    close_string(r);
                    results_due.push_back(r);
                end
                else
                begin
                    take_char(req.ch);
                end
            end
            pending = results_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the integer parser testbench: clock, reset, stimulus, output
// back-pressure, watchdog and verdict. All prediction and comparison is
// done by aip_checker, which sits beside the block on the same channels.
module tb;
    import aip_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int TARGET_ITEMS = 1300;
    // the one long output stall, started once this many results are in
    localparam int HOLD_AFTER   = 20;
    localparam int LONG_HOLD    = 300;
    // cycles with no handshake on either side before giving up
    localparam int IDLE_LIMIT   = 3000;
    // slack after the last result, so stray results are still seen
    localparam int DRAIN_CYCLES = 16;

    // number forms for the random strings
    localparam int FORM_DEC = 0;
    localparam int FORM_HEX = 1;
    localparam int FORM_BIN = 2;

    // ways to spoil a well-formed string
    localparam int BRK_SWAP = 0;
    localparam int BRK_SIGN = 1;
    localparam int BRK_CUT  = 2;

    // receiver ready patterns
    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_PULSE  = 3;

    typedef struct packed {
        logic                 cmd;
        logic [CHAR_BITS-1:0] ch;
    } char_item_t;

    logic clk;
    logic rst_n;

    aip_in_if  req_if ();
    aip_out_if rsp_if ();

    int errors;
    int pending;

    char_item_t stim[$];
    int         n_planned;
    int         n_strings;
    int         n_sent;
    int         n_results;
    int         idle_cycles;
    bit         hold_done;

    ascii_integer_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    aip_checker i_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // String builders. Everything is queued up front, then driven.
    // ---------------------------------------------------------------
    task automatic put_char(input logic [CHAR_BITS-1:0] c);
        stim.push_back('{CMD_CHAR, c});
    endtask

    task automatic put_text(input string s);
        foreach (s[i])
        begin
            put_char(s[i]);
        end
    endtask

    // the character field of an end item is don't-care, so fill it randomly
    task automatic put_end();
        stim.push_back('{CMD_END, 8'($urandom)});
        n_strings++;
    endtask

    function automatic logic [CHAR_BITS-1:0] rand_dec_char();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_BITS-1:0] rand_hex_char();
        int k;
        k = $urandom_range(0, 15);
        if (k < 10)
        begin
            return CH_ZERO + 8'(k);
        end
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(k - 10);
    endfunction

    // Either any byte at all, or one sitting right at a class boundary
    // ('/' and ':' around the digits, '@' 'G' '`' 'g' around the hex
    // letters, signs, space, the radix letters, a/A/f/F and 0/1/9).
    function automatic logic [CHAR_BITS-1:0] odd_char();
        string near_chars;
        near_chars = "/:@G`g+- xXbBaAfF019";
        if ($urandom_range(0, 1))
        begin
            return 8'($urandom);
        end
        return near_chars[$urandom_range(0, near_chars.len() - 1)];
    endfunction

    // One number in decimal, hex or binary, mostly well-formed. Digit counts
    // lean toward the limits: empty radix bodies, 8/9 hex digits, 32/33
    // binary digits, counts past the 6-bit saturation, decimal overflow.
    task automatic put_number(input bit broken);
        logic [CHAR_BITS-1:0] txt[$];
        int                   form;
        int                   pick;
        int                   n;
        int                   cut;
        bit                   all_ones;
        string                fixed;
        pick = $urandom_range(0, 99);
        form = (pick < 40) ? FORM_DEC : (pick < 70) ? FORM_HEX : FORM_BIN;
        if ($urandom_range(0, 3) == 0)
        begin
            txt.push_back(CH_MINUS);
        end
        all_ones = ($urandom_range(0, 9) == 0);
        case (form)
            FORM_DEC:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    // values around the signed and unsigned 32-bit edges
                    case ($urandom_range(0, 3))
                        0:       fixed = "2147483647";
                        1:       fixed = "2147483648";
                        2:       fixed = "4294967295";
                        default: fixed = "4294967296";
                    endcase
                    foreach (fixed[i])
                    begin
                        txt.push_back(fixed[i]);
                    end
                end
                else
                begin
                    n = (pick < 7) ? $urandom_range(1, 6) :
                        (pick < 9) ? $urandom_range(9, 10) : $urandom_range(11, 20);
                    if ($urandom_range(0, 6) == 0)
                    begin
                        txt.push_back(CH_ZERO);
                    end
                    repeat (n)
                    begin
                        txt.push_back(rand_dec_char());
                    end
                end
            end
            FORM_HEX:
            begin
                txt.push_back(CH_ZERO);
                txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                pick = $urandom_range(0, 49);
                n = (pick < 4)  ? 0 :
                    (pick < 9)  ? $urandom_range(9, 10) :
                    (pick == 9) ? $urandom_range(64, 70) : $urandom_range(1, 8);
                repeat (n)
                begin
                    if (all_ones)
                    begin
                        txt.push_back($urandom_range(0, 1) ? CH_LF : CH_UF);
                    end
                    else
                    begin
                        txt.push_back(rand_hex_char());
                    end
                end
            end
            default:
            begin
                txt.push_back(CH_ZERO);
                txt.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
                pick = $urandom_range(0, 19);
                n = (pick == 0) ? 0 :
                    (pick == 1) ? $urandom_range(60, 66) :
                    (pick < 8)  ? $urandom_range(30, 33) : $urandom_range(1, 8);
                repeat (n)
                begin
                    txt.push_back((all_ones || $urandom_range(0, 1)) ? CH_ONE : CH_ZERO);
                end
            end
        endcase
        if (broken)
        begin
            case ($urandom_range(0, 2))
                BRK_SWAP:
                begin
                    txt[$urandom_range(0, txt.size() - 1)] = odd_char();
                end
                BRK_SIGN:
                begin
                    txt.insert($urandom_range(0, txt.size()), CH_MINUS);
                end
                default:
                begin
                    cut = $urandom_range(0, txt.size() - 1);
                    while (txt.size() > cut)
                    begin
                        void'(txt.pop_back());
                    end
                end
            endcase
        end
        foreach (txt[i])
        begin
            put_char(txt[i]);
        end
        put_end();
    endtask

    task automatic put_noise();
        repeat ($urandom_range(0, 6))
        begin
            put_char(odd_char());
        end
        put_end();
    endtask

    task automatic build_stimulus();
        int pick;
        // directed: empty string, lone minus, leading zeros read as decimal,
        // radix prefixes with no digits, a plus sign, a doubled minus, NUL
        put_end();
        put_text("-");
        put_end();
        put_text("007");
        put_end();
        put_text("0x");
        put_end();
        put_text("-0B");
        put_end();
        put_text("+1");
        put_end();
        put_text("--1");
        put_end();
        put_char(8'h00);
        put_end();
        // random: mostly clean numbers, mixed with spoiled ones and plain noise
        while (stim.size() < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                put_number(1'b0);
            end
            else if (pick < 90)
            begin
                put_number(1'b1);
            end
            else
            begin
                put_noise();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Watchdog and result count. Any handshake on either side resets
    // the idle counter.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_results++;
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: rsp.ready changes on the falling edge. Patterns run in
    // stretches of random length; once, early on, ready stays low for a
    // long while so end items pile up and the input side stalls.
    // ---------------------------------------------------------------
    initial
    begin
        int stretch;
        int style;
        rsp_if.ready = 1'b0;
        stretch      = 0;
        style        = RX_FREE;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                rsp_if.ready = 1'b0;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                end
            end
            if (stretch == 0)
            begin
                stretch = $urandom_range(10, 60);
                style   = $urandom_range(RX_FREE, RX_PULSE);
            end
            stretch--;
            case (style)
                RX_FREE:   rsp_if.ready = 1'b1;
                RX_COIN:   rsp_if.ready = 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_if.ready = ($urandom_range(0, 3) == 0);
                default:   rsp_if.ready = ((stretch / 2) % 2 == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sender and verdict. Items go out in bursts with random gaps; a
    // quarter of the bursts follow the previous one with no gap at all.
    // ---------------------------------------------------------------
    initial
    begin
        int burst_left;
        int gap;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_CHAR;
        req_if.ch    = '0;
        build_stimulus();
        n_planned = stim.size();
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n      = 1'b1;
        burst_left = 0;
        while (stim.size() > 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    req_if.valid = 1'b0;
                    repeat (gap - 1)
                    begin
                        @(negedge clk);
                    end
                end
            end
            @(negedge clk);
            req_if.valid = 1'b1;
            req_if.cmd   = stim[0].cmd;
            req_if.ch    = stim[0].ch;
            do
            begin
                @(posedge clk);
            end
            while (!req_if.ready);
            void'(stim.pop_front());
            n_sent++;
            burst_left--;
        end
        @(negedge clk);
        req_if.valid = 1'b0;

        // drain, then wait DRAIN_CYCLES more for stray results
        wait (pending == 0);
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("tb: %0d of %0d items sent as %0d strings, %0d results compared",
                 n_sent, n_planned, n_strings, n_results);
        $display("tb: decimal, hex and binary forms, spoiled strings and noise; %s",
                 "one long output stall plus mixed stall patterns");
        if (errors == 0 && pending == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/aip_pkg.sv
hw/rtl/aip_in_if.sv
hw/rtl/aip_out_if.sv
hw/rtl/ascii_integer_parser.sv
tb/aip_checker.sv
tb/tb.sv
